/* design/fapi_pkg.sv */
// Shared types, constants and a helper function of the fuzzy adaptive PI position controller.
package fapi_pkg;

  // Controller limits and fuzzy universe geometry.
  localparam int OUTPUT_LIMIT = 6000;
  localparam int FUZZY_SETS   = 7;
  localparam int RULE_COUNT   = FUZZY_SETS * FUZZY_SETS;
  localparam int SEG_SHIFT    = 17;
  localparam int UNIV_HALF_Q  = 6 * 65536;

  // Serial multiplier and divider widths.
  localparam int MUL_AW = 36;
  localparam int MUL_BW = 33;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 16;

  typedef logic signed [MUL_AW-1:0] mul_a_t;
  typedef logic signed [MUL_BW-1:0] mul_b_t;
  typedef logic signed [MUL_PW-1:0] mul_p_t;

  // Command codes carried in the input word.
  localparam logic [1:0] CMD_STEP  = 2'd0;
  localparam logic [1:0] CMD_KP_WR = 2'd1;
  localparam logic [1:0] CMD_KI_WR = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_KP_GAIN   = 3'd0;
  localparam logic [2:0] REG_KI_GAIN   = 3'd1;
  localparam logic [2:0] REG_KP_DIV    = 3'd2;
  localparam logic [2:0] REG_KI_DIV    = 3'd3;
  localparam logic [2:0] REG_E_SCALE   = 3'd4;
  localparam logic [2:0] REG_D_SCALE   = 3'd5;
  localparam logic [2:0] REG_KP_FSCALE = 3'd6;
  localparam logic [2:0] REG_KI_FSCALE = 3'd7;

  // Saturate a wide signed product to the signed 32 bit range.
  function automatic logic signed [31:0] sat32(input mul_p_t v);
    logic signed [31:0] r;
    if ((&v[MUL_PW-1:31]) || !(|v[MUL_PW-1:31])) begin
      r = v[31:0];
    end else if (v[MUL_PW-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

/* design/fapi_mul.sv */
// Bit-serial signed multiplier, one multiplier bit per cycle.
module fapi_mul (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  fapi_pkg::mul_a_t a,
  input  fapi_pkg::mul_b_t b,
  output logic             done,
  output fapi_pkg::mul_p_t p
);

  logic             busy_r;
  logic             done_r;
  logic [5:0]       cnt_r;
  fapi_pkg::mul_p_t acc_r;
  fapi_pkg::mul_p_t acc_nxt;
  fapi_pkg::mul_p_t m_r;
  fapi_pkg::mul_b_t b_r;
  logic             last;

  assign last = (cnt_r == 6'(fapi_pkg::MUL_BW - 1));

  // The top multiplier bit carries negative weight, so it is subtracted.
  always_comb begin
    acc_nxt = acc_r;
    if (b_r[0]) begin
      acc_nxt = last ? (acc_r - m_r) : (acc_r + m_r);
    end
  end

  // Control: count the multiplier bits and flag completion.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
      end
    end
  end

  // Datapath: shift the multiplicand up and the multiplier down.
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      m_r   <= fapi_pkg::mul_p_t'(a);
      b_r   <= b;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      m_r   <= m_r <<< 1;
      b_r   <= b_r >>> 1;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

/* design/fapi_div.sv */
// Bit-serial restoring divider, signed dividend over unsigned divisor, truncating toward zero.
module fapi_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [fapi_pkg::DIV_NW-1:0]   dividend,
  input  logic        [fapi_pkg::DIV_DW-1:0]   divisor,
  output logic                                 done,
  output logic signed [fapi_pkg::DIV_NW-1:0]   quotient
);

  logic                          busy_r;
  logic                          done_r;
  logic [4:0]                    cnt_r;
  logic                          neg_r;
  logic [fapi_pkg::DIV_NW-1:0]   quo_r;
  logic [fapi_pkg::DIV_DW-1:0]   rem_r;
  logic [fapi_pkg::DIV_DW-1:0]   den_r;
  logic [fapi_pkg::DIV_DW:0]     shifted;
  logic [fapi_pkg::DIV_DW+1:0]   diff;
  logic                          last;

  assign last    = (cnt_r == 5'(fapi_pkg::DIV_NW - 1));
  assign shifted = {rem_r, quo_r[fapi_pkg::DIV_NW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};

  // Control: one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
      end
    end
  end

  // Datapath: the dividend magnitude shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[fapi_pkg::DIV_NW-1];
      quo_r <= dividend[fapi_pkg::DIV_NW-1] ? (-dividend) : dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      if (!diff[fapi_pkg::DIV_DW+1]) begin
        rem_r <= diff[fapi_pkg::DIV_DW-1:0];
        quo_r <= {quo_r[fapi_pkg::DIV_NW-2:0], 1'b1};
      end else begin
        rem_r <= shifted[fapi_pkg::DIV_DW-1:0];
        quo_r <= {quo_r[fapi_pkg::DIV_NW-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (-quo_r) : quo_r;

endmodule

/* design/fuzzy_adaptive_pi_position.sv */
// Top level of the fuzzy self-tuning PI position controller.
// A rule write (or an unused command) goes through S_DONE into the output register once that is free,
// and then back to idle, where the next word is taken. A control step runs eighteen serial multiplies on one
// shared bit-serial multiplier (scaling of error and change, four membership weights, eight rule blends,
// two gain corrections, two gain products), two divides on one bit-serial divider, and four single-port
// reads of the rule tables. One item is worked on at a time; a new word is taken while the previous
// result still waits in the output register. Both rule tables must be fully written before the first
// control step; there is no clearing pass after reset.
module fuzzy_adaptive_pi_position (
  input  logic        clk,
  input  logic        rst_n,
  // Input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,  // position_error[31:0], rule_slot[37:32], rule_value[53:38]
  input  logic [1:0]  in_tuser,  // command[1:0]
  // Result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // drive[13:0], limited[14], integral_now[46:15]
  // Configuration writes
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // Sequencer states.
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_QE   = 4'd1;
  localparam logic [3:0] S_QC   = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_W    = 4'd4;
  localparam logic [3:0] S_BP   = 4'd5;
  localparam logic [3:0] S_BI   = 4'd6;
  localparam logic [3:0] S_FP   = 4'd7;
  localparam logic [3:0] S_PE   = 4'd8;
  localparam logic [3:0] S_FI   = 4'd9;
  localparam logic [3:0] S_IE   = 4'd10;
  localparam logic [3:0] S_DP   = 4'd11;
  localparam logic [3:0] S_DI   = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  localparam fapi_pkg::mul_p_t UNIV_LIM = fapi_pkg::mul_p_t'(fapi_pkg::UNIV_HALF_Q);
  localparam logic [19:0]      UNIV_OFS = 20'(fapi_pkg::UNIV_HALF_Q);
  localparam logic [17:0]      W_ONE    = 18'(1 << fapi_pkg::SEG_SHIFT);
  localparam logic [51:0]      BLEND_BIAS = (52'd1 << (2 * fapi_pkg::SEG_SHIFT)) - 52'd1;
  localparam logic signed [32:0] O_LIM  = 33'(fapi_pkg::OUTPUT_LIMIT);
  localparam logic signed [34:0] O_LIM35 = 35'(fapi_pkg::OUTPUT_LIMIT);

  // Configuration registers.
  logic signed [15:0] kp_gain_r, ki_gain_r, kp_fscale_r, ki_fscale_r;
  logic        [15:0] kp_div_r, ki_div_r;
  logic signed [31:0] e_scale_r, d_scale_r;

  // Sequencer and controller state.
  logic [3:0]         state_r, state_nxt;
  logic               issued_r;
  logic signed [31:0] prev_r;
  logic signed [31:0] integ_r;

  // Working registers of one control step.
  logic signed [31:0] e_r;
  logic signed [32:0] delta_r;
  logic        [28:0] lim_r;
  logic        [2:0]  se_r, sc_r;
  logic        [17:0] he_r, hc_r;
  logic        [1:0]  k_r;
  fapi_pkg::mul_a_t   w_r;
  fapi_pkg::mul_a_t   g_r;
  logic signed [15:0] kpq_r, kiq_r;
  logic signed [51:0] sum_kp_r, sum_ki_r;
  logic signed [31:0] p_r, qp_r;
  logic        [13:0] res_drive_r;
  logic               res_lim_r;

  // Output register.
  logic               out_valid_r;
  logic        [13:0] out_drive_r;
  logic               out_lim_r;
  logic        [31:0] out_integ_r;

  // Rule tables.
  logic signed [15:0] kp_mem [0:fapi_pkg::RULE_COUNT-1];
  logic signed [15:0] ki_mem [0:fapi_pkg::RULE_COUNT-1];

  // Input word fields.
  logic        [1:0]  in_cmd;
  logic signed [31:0] in_err;
  logic        [5:0]  in_slot;
  logic signed [15:0] in_value;
  logic               in_acc;
  logic               slot_ok;

  assign in_cmd   = in_tuser;
  assign in_err   = in_tdata[31:0];
  assign in_slot  = in_tdata[37:32];
  assign in_value = in_tdata[53:38];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign slot_ok  = (in_slot < 6'(fapi_pkg::RULE_COUNT));

  // Shared arithmetic units.
  logic               mul_go, mul_done;
  fapi_pkg::mul_a_t   mul_a;
  fapi_pkg::mul_b_t   mul_b;
  fapi_pkg::mul_p_t   mul_p;
  logic               div_go, div_done;
  logic signed [31:0] div_n, div_q;
  logic        [15:0] div_d;
  logic               mul_state, div_state;

  fapi_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  fapi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // Divisors of zero act as one.
  logic [15:0] kpd, kid;
  assign kpd = (kp_div_r == 16'd0) ? 16'd1 : kp_div_r;
  assign kid = (ki_div_r == 16'd0) ? 16'd1 : ki_div_r;

  // Membership weights of the current segment pair.
  logic [17:0] le, lc;
  assign le = W_ONE - he_r;
  assign lc = W_ONE - hc_r;

  // Blended rule outputs, truncated toward zero.
  logic signed [51:0] fkp_sum, fki_sum;
  logic signed [16:0] fkp, fki;
  assign fkp_sum = sum_kp_r + (sum_kp_r[51] ? BLEND_BIAS : 52'd0);
  assign fki_sum = sum_ki_r + (sum_ki_r[51] ? BLEND_BIAS : 52'd0);
  assign fkp     = fkp_sum[50:34];
  assign fki     = fki_sum[50:34];

  // Rule table address of the current corner.
  logic [5:0] r0, rd_addr;
  assign r0      = {se_r, 3'b000} - {3'b000, se_r} + {3'b000, sc_r};
  assign rd_addr = r0 + (k_r[1] ? 6'd7 : 6'd0) + (k_r[0] ? 6'd1 : 6'd0);

  // Scale into the universe: clamp, then split into segment and upper weight.
  function automatic logic [20:0] fuzz(input fapi_pkg::mul_p_t q);
    fapi_pkg::mul_p_t qc;
    logic [19:0]      u;
    logic [2:0]       s;
    logic [17:0]      h;
    qc = q;
    if (q > UNIV_LIM) begin
      qc = UNIV_LIM;
    end else if (q < -UNIV_LIM) begin
      qc = -UNIV_LIM;
    end
    u = qc[19:0] + UNIV_OFS;
    if (u[19:17] > 3'd5) begin
      s = 3'd5;
      h = W_ONE;
    end else begin
      s = u[19:17];
      h = {1'b0, u[16:0]};
    end
    return {s, h};
  endfunction

  logic [20:0] fz;
  assign fz = fuzz(mul_p);

  // Operand selection for the shared units.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_QE: begin
        mul_a = fapi_pkg::mul_a_t'(e_scale_r);
        mul_b = fapi_pkg::mul_b_t'(e_r);
      end
      S_QC: begin
        mul_a = fapi_pkg::mul_a_t'(d_scale_r);
        mul_b = delta_r;
      end
      S_W: begin
        mul_a = fapi_pkg::mul_a_t'(k_r[1] ? he_r : le);
        mul_b = fapi_pkg::mul_b_t'(k_r[0] ? hc_r : lc);
      end
      S_BP: begin
        mul_a = w_r;
        mul_b = fapi_pkg::mul_b_t'(kpq_r);
      end
      S_BI: begin
        mul_a = w_r;
        mul_b = fapi_pkg::mul_b_t'(kiq_r);
      end
      S_FP: begin
        mul_a = fapi_pkg::mul_a_t'(kp_fscale_r);
        mul_b = fapi_pkg::mul_b_t'(fkp);
      end
      S_FI: begin
        mul_a = fapi_pkg::mul_a_t'(ki_fscale_r);
        mul_b = fapi_pkg::mul_b_t'(fki);
      end
      S_PE, S_IE: begin
        mul_a = g_r;
        mul_b = fapi_pkg::mul_b_t'(e_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_state = (state_r inside {S_QE, S_QC, S_W, S_BP, S_BI, S_FP, S_PE, S_FI, S_IE});
  assign div_state = (state_r == S_DP) || (state_r == S_DI);
  assign mul_go    = mul_state && !issued_r;
  assign div_go    = div_state && !issued_r;
  assign div_n     = (state_r == S_DP) ? p_r : integ_r;
  assign div_d     = (state_r == S_DP) ? kpd : kid;

  // Integral update after the integral gain product.
  logic signed [31:0] it_sat;
  logic signed [32:0] isum, lim33, nlim33;
  logic signed [31:0] integ_ie;
  assign it_sat = fapi_pkg::sat32(mul_p);
  assign isum   = 33'(integ_r) + 33'(it_sat);
  assign lim33  = signed'({4'b0000, lim_r});
  assign nlim33 = -lim33;
  always_comb begin
    if (ki_gain_r == 16'sd0) begin
      integ_ie = '0;
    end else if (isum > lim33) begin
      integ_ie = lim33[31:0];
    end else if (isum < nlim33) begin
      integ_ie = nlim33[31:0];
    end else begin
      integ_ie = isum[31:0];
    end
  end

  // Output sum, clamp and discharge of the excess into the integral.
  logic signed [32:0] o_sum;
  logic signed [34:0] dis_hi, dis_lo;
  logic signed [31:0] integ_di;
  logic        [13:0] drive_di;
  logic               lim_di;
  assign o_sum  = 33'(qp_r) + 33'(div_q);
  assign dis_hi = 35'(integ_r) + O_LIM35 - 35'(o_sum);
  assign dis_lo = 35'(integ_r) - O_LIM35 - 35'(o_sum);
  always_comb begin
    if (o_sum > O_LIM) begin
      integ_di = fapi_pkg::sat32(fapi_pkg::mul_p_t'(dis_hi));
      drive_di = O_LIM[13:0];
      lim_di   = 1'b1;
    end else if (o_sum < -O_LIM) begin
      integ_di = fapi_pkg::sat32(fapi_pkg::mul_p_t'(dis_lo));
      drive_di = 14'(-O_LIM);
      lim_di   = 1'b1;
    end else begin
      integ_di = integ_r;
      drive_di = o_sum[13:0];
      lim_di   = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc) begin
        state_nxt = (in_cmd == fapi_pkg::CMD_STEP) ? S_QE : S_DONE;
      end
      S_QE:  if (mul_done) state_nxt = S_QC;
      S_QC:  if (mul_done) state_nxt = S_RD;
      S_RD:  state_nxt = S_W;
      S_W:   if (mul_done) state_nxt = S_BP;
      S_BP:  if (mul_done) state_nxt = S_BI;
      S_BI:  if (mul_done) state_nxt = (k_r == 2'd3) ? S_FP : S_RD;
      S_FP:  if (mul_done) state_nxt = S_PE;
      S_PE:  if (mul_done) state_nxt = S_FI;
      S_FI:  if (mul_done) state_nxt = S_IE;
      S_IE:  if (mul_done) state_nxt = S_DP;
      S_DP:  if (div_done) state_nxt = S_DI;
      S_DI:  if (div_done) state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_tready) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers, configuration and controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      prev_r      <= '0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
      kp_gain_r   <= 16'sd8;
      ki_gain_r   <= 16'sd2;
      kp_div_r    <= 16'd2048;
      ki_div_r    <= 16'd2048;
      e_scale_r   <= 32'sd13107;
      d_scale_r   <= 32'sd1311;
      kp_fscale_r <= 16'sd35;
      ki_fscale_r <= 16'sd1;
    end else begin
      state_r <= state_nxt;

      // A unit is started once on entry to its state.
      if (mul_done || div_done) begin
        issued_r <= 1'b0;
      end else if (mul_go || div_go) begin
        issued_r <= 1'b1;
      end

      if (state_r == S_IE && mul_done) begin
        integ_r <= integ_ie;
      end
      if (state_r == S_DI && div_done) begin
        integ_r <= integ_di;
        prev_r  <= e_r;
      end

      // Output register handshake.
      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          fapi_pkg::REG_KP_GAIN:   kp_gain_r   <= cfg_wdata[15:0];
          fapi_pkg::REG_KI_GAIN:   ki_gain_r   <= cfg_wdata[15:0];
          fapi_pkg::REG_KP_DIV:    kp_div_r    <= cfg_wdata[15:0];
          fapi_pkg::REG_KI_DIV:    ki_div_r    <= cfg_wdata[15:0];
          fapi_pkg::REG_E_SCALE:   e_scale_r   <= cfg_wdata;
          fapi_pkg::REG_D_SCALE:   d_scale_r   <= cfg_wdata;
          fapi_pkg::REG_KP_FSCALE: kp_fscale_r <= cfg_wdata[15:0];
          fapi_pkg::REG_KI_FSCALE: ki_fscale_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  // Working registers of the step.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      e_r      <= in_err;
      delta_r  <= 33'(in_err) - 33'(prev_r);
      lim_r    <= {13'd0, kid} * 29'(fapi_pkg::OUTPUT_LIMIT);
      sum_kp_r <= '0;
      sum_ki_r <= '0;
      k_r      <= '0;
      res_drive_r <= '0;
      res_lim_r   <= 1'b0;
    end
    if (mul_done) begin
      case (state_r)
        S_QE: {se_r, he_r} <= fz;
        S_QC: {sc_r, hc_r} <= fz;
        S_W:  w_r <= mul_p[fapi_pkg::MUL_AW-1:0];
        S_BP: sum_kp_r <= sum_kp_r + mul_p[51:0];
        S_BI: begin
          sum_ki_r <= sum_ki_r + mul_p[51:0];
          k_r      <= k_r + 2'd1;
        end
        S_FP: g_r <= fapi_pkg::mul_a_t'(kp_gain_r) + mul_p[fapi_pkg::MUL_AW-1:0];
        S_PE: p_r <= fapi_pkg::sat32(mul_p);
        S_FI: g_r <= fapi_pkg::mul_a_t'(ki_gain_r) + mul_p[fapi_pkg::MUL_AW-1:0];
        default: ;
      endcase
    end
    if (div_done && state_r == S_DP) begin
      qp_r <= div_q;
    end
    if (div_done && state_r == S_DI) begin
      res_drive_r <= drive_di;
      res_lim_r   <= lim_di;
    end
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_drive_r <= res_drive_r;
      out_lim_r   <= res_lim_r;
      out_integ_r <= integ_r;
    end
  end

  // Rule tables: written on accepted rule commands with a slot in range, read one corner in each S_RD state.
  always_ff @(posedge clk) begin
    if (in_acc && slot_ok && in_cmd == fapi_pkg::CMD_KP_WR) begin
      kp_mem[in_slot] <= in_value;
    end
    if (in_acc && slot_ok && in_cmd == fapi_pkg::CMD_KI_WR) begin
      ki_mem[in_slot] <= in_value;
    end
    if (state_r == S_RD) begin
      kpq_r <= kp_mem[rd_addr];
      kiq_r <= ki_mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_integ_r, out_lim_r, out_drive_r};

endmodule

/* design/fapi_checker.sv */
// Port-level checks of the fuzzy adaptive PI position controller, bound to the top level.
module fapi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  localparam logic signed [13:0] LIM = 14'(fapi_pkg::OUTPUT_LIMIT);

  logic signed [13:0] drive;
  assign drive = out_tdata[13:0];

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // The drive never leaves the output limit.
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (drive <= LIM) && (drive >= -LIM))
    else $error("drive outside the output limit");

  // A clamped result sits exactly on the limit.
  a_limited_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[14] |-> (drive == LIM) || (drive == -LIM))
    else $error("limited flag without drive at the limit");

  // One word is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while busy");

endmodule

bind fuzzy_adaptive_pi_position fapi_checker u_fapi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
